// ===== src/gddm_pkg.sv =====
// ----------------------------------------------------------------------------
// gddm_pkg: shared definitions of the grid distance map unit
// Item formats, opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package gddm_pkg;

  localparam int          OPCODE_W   = 3;
  localparam int          CELL_W     = 12;
  localparam int          KIND_W     = 3;
  localparam int          DIST_W     = 8;
  localparam int          SIDE_W     = 7;
  localparam logic [7:0]  NO_DIST    = 8'd255;
  localparam logic [7:0]  SAT_DIST   = 8'd254;
  localparam logic [6:0]  SIDE_RESET = 7'd64;

  // Register index, taken from paddr[2].
  localparam logic REG_GRID_SIDE = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_SET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PROP   = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_SETW,
    ST_RES,
    ST_OUT,
    ST_POP,
    ST_PCELL,
    ST_ENTRY,
    ST_ALIVE,
    ST_DIVC,
    ST_DIVS,
    ST_NB,
    ST_NADDR,
    ST_NREC,
    ST_NALIVE,
    ST_NEXT
  } st_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CELL_W-1:0]   cell_req;
    logic [KIND_W-1:0]   kind;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CELL_W-1:0] nearest_cell;
    logic              has_source;
    logic              queue_overflow;
  } out_item_t;

endpackage

// ===== src/gddm_chan_if.sv =====
// ----------------------------------------------------------------------------
// gddm_chan_if: valid/ready channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface gddm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/gddm_ram.sv =====
// ----------------------------------------------------------------------------
// gddm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gddm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/gddm_div.sv =====
// ----------------------------------------------------------------------------
// gddm_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module gddm_div #(
  parameter int DW = 12,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic          done
);
  localparam int CNW = $clog2(DW);

  logic [DW-1:0]  quo_r, quo_nxt;
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [VW:0]    trial;
  logic           ge;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    ge       = trial >= {1'b0, divisor};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? VW'(trial - {1'b0, divisor}) : VW'(trial);
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;
endmodule

// ===== src/grid_dynamic_distance_map_unit.sv =====
// ----------------------------------------------------------------------------
// grid_dynamic_distance_map_unit: dynamic brushfire distance map
// Per cell and source kind, Manhattan distance to and index of the nearest
// source, updated by raise and lower waves drained from a FIFO work queue.
// ----------------------------------------------------------------------------
// Usage: each input item carries an opcode and produces exactly one result
// item that reports the addressed entry after the operation. The entry store
// is a single RAM of GRID_MAX*GRID_MAX*NUM_KINDS words (20480 by default), and
// after reset and after every clear item the unit sweeps it, one word per
// cycle; the unit accepts no item until the sweep after reset is over. Query,
// remove and unknown opcodes pass from acceptance through a result read to
// the output register, and a set first reads the entry to keep a pending
// raise mark. A propagate item pops the work queue until it is empty; each
// popped item costs queue and entry reads, one or two divisions of a cell
// index by the grid side in the shared divider, and a visit to each of the
// four neighbors, with more entry reads for a neighbor inside the grid. The
// entry RAM's single read port and the divider set the pace, so a propagate
// takes time in proportion to the size of the wave. The unit works on one
// item at a time; a finished result waits in the output register while the
// next item is accepted.
module grid_dynamic_distance_map_unit #(
  parameter int GRID_MAX    = 64,
  parameter int NUM_KINDS   = 5,
  parameter int QUEUE_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  gddm_chan_if.sink   in_ch,
  gddm_chan_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gddm_pkg::*;

  localparam int CELLS   = GRID_MAX * GRID_MAX;
  localparam int CW      = $clog2(CELLS);
  localparam int KW      = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int ENTRIES = CELLS * NUM_KINDS;
  localparam int EW      = $clog2(ENTRIES);
  localparam int SW      = $clog2(GRID_MAX + 1);
  localparam int CRW     = $clog2(GRID_MAX);
  localparam int QW      = $clog2(QUEUE_DEPTH);
  localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
  localparam int QDW     = CW + KW;

  // One word of the entry store: raise flag, valid bit, source cell, distance.
  typedef struct packed {
    logic          raise;
    logic          valid;
    logic [CW-1:0] near;
    logic [7:0]    dval;
  } rec_t;
  localparam int RW = $bits(rec_t);

  function automatic logic [EW-1:0] ent_addr(input logic [CW-1:0] c,
                                             input logic [KW-1:0] k);
    return EW'(c) * EW'(NUM_KINDS) + EW'(k);
  endfunction

  function automatic logic near_ok(input logic [CW-1:0] c);
    return 32'(c) < CELLS;
  endfunction

  // Sequencer and item registers.
  st_t            state_r, state_nxt;
  logic [6:0]     grid_side_r, grid_side_nxt;
  logic [EW-1:0]  clr_idx_r, clr_idx_nxt;
  logic           report_r, report_nxt;
  logic [CW-1:0]  cell_r, cell_nxt;
  logic           ok_r, ok_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  // Visit registers.
  logic [CW-1:0]  qc_r, qc_nxt;
  logic [KW-1:0]  qk_r, qk_nxt;
  logic [EW-1:0]  pe_r, pe_nxt;
  rec_t           erec_r, erec_nxt;
  logic [CRW-1:0] x_r, x_nxt, y_r, y_nxt, sx_r, sx_nxt;
  // The source row can exceed the grid when the side changed since the set.
  logic [CW-1:0]  sy_r, sy_nxt;
  logic [1:0]     nb_r, nb_nxt;
  logic [CRW-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [EW-1:0]  ne_r, ne_nxt;
  rec_t           nrec_r, nrec_nxt;
  // Work queue pointers and sticky overflow.
  logic [QW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  // Output register.
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  // Memory and divider hookup.
  logic           ram_we;
  logic [EW-1:0]  ram_waddr, ram_raddr;
  rec_t           ram_wdata, ram_rdata;
  logic [RW-1:0]  ram_rdata_raw;
  logic           q_we;
  logic [QDW-1:0] q_wdata, q_rdata;
  logic           div_start, div_done;
  logic [CW-1:0]  div_dvd, div_quo;
  logic [SW-1:0]  div_rem;

  logic           push_req;
  logic [CW-1:0]  push_cell;
  logic [KW-1:0]  push_kind;

  logic [SW-1:0]  side_w;
  logic [2*SW-1:0] side_sq;
  in_item_t       in_item;
  logic           in_ok;
  logic [CW-1:0]  in_cell;
  logic [KW-1:0]  in_kind;
  logic [CW-1:0]  pop_cell;
  logic [KW-1:0]  pop_kind;
  logic           pop_ok;
  logic [CW:0]    dsum;
  logic [7:0]     dman;
  logic           nb_in;
  logic [CRW-1:0] nb_x, nb_y;
  logic           alive;
  rec_t           wipe_rec;

  assign wipe_rec = '{raise: 1'b0, valid: 1'b0, near: '0, dval: NO_DIST};

  // Grid side in use: zero counts as one, anything above GRID_MAX is clipped.
  always_comb begin
    if (grid_side_r == 7'd0) begin
      side_w = SW'(1);
    end else if (32'(grid_side_r) > GRID_MAX) begin
      side_w = SW'(GRID_MAX);
    end else begin
      side_w = SW'(grid_side_r);
    end
  end
  assign side_sq = side_w * side_w;

  assign in_item = in_ch.data;
  assign in_ok   = (32'(in_item.cell_req) < 32'(side_sq)) &&
                   (32'(in_item.cell_req) < CELLS) &&
                   (32'(in_item.kind) < NUM_KINDS);
  assign in_cell = CW'(in_item.cell_req);
  assign in_kind = KW'(in_item.kind);

  assign pop_cell = q_rdata[QDW-1:KW];
  assign pop_kind = q_rdata[KW-1:0];
  assign pop_ok   = (32'(pop_cell) < 32'(side_sq)) && near_ok(pop_cell) &&
                    (32'(pop_kind) < NUM_KINDS);

  // Manhattan distance from the visit's source to the current neighbor,
  // saturated so that the no-source code is never produced.
  always_comb begin
    dsum = ((sx_r > nx_r) ? (CW+1)'(sx_r - nx_r) : (CW+1)'(nx_r - sx_r)) +
           ((sy_r > CW'(ny_r)) ? (CW+1)'(sy_r - CW'(ny_r))
                               : (CW+1)'(CW'(ny_r) - sy_r));
    dman = (32'(dsum) > 32'(SAT_DIST)) ? SAT_DIST : 8'(dsum);
  end

  // Neighbor order: left, right, up, down.
  always_comb begin
    nb_x  = x_r;
    nb_y  = y_r;
    nb_in = 1'b0;
    case (nb_r)
      2'd0: begin
        nb_in = x_r != '0;
        nb_x  = x_r - 1'b1;
      end
      2'd1: begin
        nb_in = (SW'(x_r) + SW'(1)) < side_w;
        nb_x  = x_r + 1'b1;
      end
      2'd2: begin
        nb_in = y_r != '0;
        nb_y  = y_r - 1'b1;
      end
      default: begin
        nb_in = (SW'(y_r) + SW'(1)) < side_w;
        nb_y  = y_r + 1'b1;
      end
    endcase
  end

  assign ram_rdata = rec_t'(ram_rdata_raw);
  assign alive = near_ok(nrec_r.near) && ram_rdata.valid &&
                 (ram_rdata.near == nrec_r.near);

  always_comb begin
    state_nxt     = state_r;
    grid_side_nxt = grid_side_r;
    clr_idx_nxt   = clr_idx_r;
    report_nxt    = report_r;
    cell_nxt      = cell_r;
    ok_nxt        = ok_r;
    e_nxt         = e_r;
    qc_nxt        = qc_r;
    qk_nxt        = qk_r;
    pe_nxt        = pe_r;
    erec_nxt      = erec_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    nb_nxt        = nb_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    n_nxt         = n_r;
    ne_nxt        = ne_r;
    nrec_nxt      = nrec_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = ne_r;
    ram_wdata     = wipe_rec;
    ram_raddr     = e_r;
    q_we          = 1'b0;
    div_start     = 1'b0;
    div_dvd       = qc_r;
    push_req      = 1'b0;
    push_cell     = n_r;
    push_kind     = qk_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // The only register is the grid side; other addresses are ignored.
    if (psel && penable && pwrite && (paddr[2] == REG_GRID_SIDE)) begin
      grid_side_nxt = pwdata[6:0];
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = wipe_rec;
        if (clr_idx_r == EW'(ENTRIES - 1)) begin
          clr_idx_nxt = '0;
          state_nxt   = report_r ? ST_RES : ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          cell_nxt = in_cell;
          ok_nxt   = in_ok;
          e_nxt    = in_ok ? ent_addr(in_cell, in_kind) : '0;
          case (in_item.opcode)
            OP_CLEAR: begin
              head_nxt    = '0;
              tail_nxt    = '0;
              count_nxt   = '0;
              ovf_nxt     = 1'b0;
              report_nxt  = 1'b1;
              clr_idx_nxt = '0;
              state_nxt   = ST_CLR;
            end
            OP_SET: begin
              if (in_ok) begin
                ram_raddr = ent_addr(in_cell, in_kind);
                qk_nxt    = in_kind;
                state_nxt = ST_SETW;
              end else begin
                state_nxt = ST_RES;
              end
            end
            OP_REMOVE: begin
              if (in_ok) begin
                ram_we    = 1'b1;
                ram_waddr = ent_addr(in_cell, in_kind);
                ram_wdata = '{raise: 1'b1, valid: 1'b0, near: '0, dval: NO_DIST};
                push_req  = 1'b1;
                push_cell = in_cell;
                push_kind = in_kind;
              end
              state_nxt = ST_RES;
            end
            OP_PROP: begin
              state_nxt = ST_POP;
            end
            default: begin
              state_nxt = ST_RES;
            end
          endcase
        end
      end
      ST_SETW: begin
        // A set keeps a pending raise mark, so the entry still raises its
        // old region at the next propagate.
        ram_we    = 1'b1;
        ram_waddr = e_r;
        ram_wdata = '{raise: ram_rdata.raise, valid: 1'b1, near: cell_r, dval: 8'd0};
        push_req  = 1'b1;
        push_cell = cell_r;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        ram_raddr = e_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        ram_raddr = e_r;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (ok_r && ram_rdata.valid) begin
            out_data_nxt.distance     = ram_rdata.dval;
            out_data_nxt.nearest_cell = CELL_W'(ram_rdata.near);
            out_data_nxt.has_source   = 1'b1;
          end else begin
            out_data_nxt.distance     = ok_r ? ram_rdata.dval : NO_DIST;
            out_data_nxt.nearest_cell = '0;
            out_data_nxt.has_source   = 1'b0;
          end
          out_data_nxt.queue_overflow = ovf_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        if (count_r == '0) begin
          state_nxt = ST_RES;
        end else begin
          head_nxt  = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_PCELL;
        end
      end
      ST_PCELL: begin
        qc_nxt = pop_cell;
        qk_nxt = pop_kind;
        if (pop_ok) begin
          ram_raddr = ent_addr(pop_cell, pop_kind);
          pe_nxt    = ent_addr(pop_cell, pop_kind);
          state_nxt = ST_ENTRY;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_ENTRY: begin
        erec_nxt = ram_rdata;
        if (ram_rdata.raise) begin
          div_start = 1'b1;
          div_dvd   = qc_r;
          state_nxt = ST_DIVC;
        end else if (!ram_rdata.valid || !near_ok(ram_rdata.near)) begin
          state_nxt = ST_POP;
        end else begin
          ram_raddr = ent_addr(ram_rdata.near, qk_r);
          state_nxt = ST_ALIVE;
        end
      end
      ST_ALIVE: begin
        // A lowering visit only spreads from a source that still exists.
        if (ram_rdata.valid && (ram_rdata.near == erec_r.near)) begin
          div_start = 1'b1;
          div_dvd   = qc_r;
          state_nxt = ST_DIVC;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_DIVC: begin
        if (div_done) begin
          x_nxt  = CRW'(div_rem);
          y_nxt  = CRW'(div_quo);
          nb_nxt = '0;
          if (erec_r.raise) begin
            state_nxt = ST_NB;
          end else begin
            div_start = 1'b1;
            div_dvd   = erec_r.near;
            state_nxt = ST_DIVS;
          end
        end
      end
      ST_DIVS: begin
        if (div_done) begin
          sx_nxt    = CRW'(div_rem);
          sy_nxt    = div_quo;
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        if (nb_in) begin
          nx_nxt    = nb_x;
          ny_nxt    = nb_y;
          n_nxt     = CW'(SW'(nb_y) * side_w + (2*SW)'(nb_x));
          state_nxt = ST_NADDR;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NADDR: begin
        ram_raddr = ent_addr(n_r, qk_r);
        ne_nxt    = ent_addr(n_r, qk_r);
        state_nxt = ST_NREC;
      end
      ST_NREC: begin
        nrec_nxt  = ram_rdata;
        state_nxt = ST_NEXT;
        if (erec_r.raise) begin
          // Raise wave: follow entries that still hold a source and are not
          // already raising; the source check needs one more read.
          if (ram_rdata.valid && !ram_rdata.raise) begin
            ram_raddr = ent_addr(ram_rdata.near, qk_r);
            state_nxt = ST_NALIVE;
          end
        end else if (!ram_rdata.raise && (dman < ram_rdata.dval)) begin
          ram_we    = 1'b1;
          ram_waddr = ne_r;
          ram_wdata = '{raise: 1'b0, valid: 1'b1, near: erec_r.near, dval: dman};
          push_req  = 1'b1;
        end
      end
      ST_NALIVE: begin
        if (!alive) begin
          ram_we    = 1'b1;
          ram_waddr = ne_r;
          ram_wdata = '{raise: 1'b1, valid: 1'b0, near: '0, dval: NO_DIST};
        end
        push_req  = 1'b1;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (nb_r == 2'd3) begin
          if (erec_r.raise) begin
            ram_we          = 1'b1;
            ram_waddr       = pe_r;
            ram_wdata       = erec_r;
            ram_wdata.raise = 1'b0;
          end
          state_nxt = ST_POP;
        end else begin
          nb_nxt    = nb_r + 1'b1;
          state_nxt = ST_NB;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Work queue push; a full queue drops the item and sets the sticky flag.
    if (push_req) begin
      if (count_r == QCW'(QUEUE_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        q_we      = 1'b1;
        tail_nxt  = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign q_wdata = {push_cell, push_kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      grid_side_r <= SIDE_RESET;
      clr_idx_r   <= '0;
      report_r    <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grid_side_r <= grid_side_nxt;
      clr_idx_r   <= clr_idx_nxt;
      report_r    <= report_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cell_r     <= cell_nxt;
    ok_r       <= ok_nxt;
    e_r        <= e_nxt;
    qc_r       <= qc_nxt;
    qk_r       <= qk_nxt;
    pe_r       <= pe_nxt;
    erec_r     <= erec_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    nb_r       <= nb_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    n_r        <= n_nxt;
    ne_r       <= ne_nxt;
    nrec_r     <= nrec_nxt;
    out_data_r <= out_data_nxt;
  end

  gddm_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  gddm_ram #(
    .WIDTH (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  gddm_div #(
    .DW (CW),
    .VW (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (side_w),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign prdata       = (paddr[2] == REG_GRID_SIDE) ? {25'd0, grid_side_r} : 32'd0;
  assign pready       = 1'b1;
endmodule

// ===== verif/gddm_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gddm_map_checker: result checker of the grid distance map unit
// Watches the input, result and register ports, keeps its own copy of the
// distance map, and compares every result item with the expected one.
// ----------------------------------------------------------------------------
module gddm_map_checker
  import gddm_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int NUM_KINDS   = 5,
  parameter int QUEUE_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          fail_count
);

  localparam int CELLS     = GRID_MAX * GRID_MAX;
  localparam int ENTRIES   = CELLS * NUM_KINDS;
  localparam int EXP_DEPTH = 1024;

  logic [7:0]  dist_mem  [ENTRIES];
  int          near_mem  [ENTRIES];
  bit          near_ok   [ENTRIES];
  bit          raise_mem [ENTRIES];
  int          wave_cell [QUEUE_DEPTH];
  int          wave_kind [QUEUE_DEPTH];
  int          wave_head;
  int          wave_count;
  bit          ovf;
  logic [6:0]  side_reg;
  out_item_t   exp_mem [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;

  function automatic int side_now();
    if (side_reg == 0) return 1;
    if (side_reg > GRID_MAX) return GRID_MAX;
    return side_reg;
  endfunction

  function automatic void wave_push(int cidx, int kind);
    if (wave_count >= QUEUE_DEPTH) begin
      ovf = 1'b1;
      return;
    end
    wave_cell[(wave_head + wave_count) % QUEUE_DEPTH] = cidx;
    wave_kind[(wave_head + wave_count) % QUEUE_DEPTH] = kind;
    wave_count++;
  endfunction

  function automatic void wipe(int e);
    dist_mem[e] = NO_DIST;
    near_mem[e] = 0;
    near_ok[e]  = 1'b0;
  endfunction

  function automatic void wipe_map();
    for (int e = 0; e < ENTRIES; e++) begin
      wipe(e);
      raise_mem[e] = 1'b0;
    end
    wave_head  = 0;
    wave_count = 0;
    ovf        = 1'b0;
  endfunction

  // An entry's source is alive while that source cell still points at itself.
  function automatic bit source_alive(int e, int kind);
    int c;
    int se;
    if (!near_ok[e]) return 1'b0;
    c = near_mem[e];
    if (c >= CELLS) return 1'b0;
    se = c * NUM_KINDS + kind;
    return near_ok[se] && near_mem[se] == c;
  endfunction

  function automatic int grid_dist(int a, int b, int s);
    int d;
    d = ((a % s > b % s) ? a % s - b % s : b % s - a % s)
      + ((a / s > b / s) ? a / s - b / s : b / s - a / s);
    return (d > SAT_DIST) ? SAT_DIST : d;
  endfunction

  // One popped cell: a raise visit clears stale neighbors, a lower visit
  // offers its source to the neighbors in the order left, right, up, down.
  function automatic void visit_cell(int cidx, int kind, int s);
    int e;
    int x;
    int y;
    int nx;
    int ny;
    int n;
    int ne;
    int d;
    bit raising;
    e = cidx * NUM_KINDS + kind;
    raising = raise_mem[e];
    if (!raising && !source_alive(e, kind)) return;
    x = cidx % s;
    y = cidx / s;
    for (int i = 0; i < 4; i++) begin
      nx = x + ((i == 0) ? -1 : (i == 1) ? 1 : 0);
      ny = y + ((i == 2) ? -1 : (i == 3) ? 1 : 0);
      if (nx < 0 || ny < 0 || nx >= s || ny >= s) continue;
      n  = ny * s + nx;
      ne = n * NUM_KINDS + kind;
      if (raising) begin
        if (near_ok[ne] && !raise_mem[ne]) begin
          if (!source_alive(ne, kind)) begin
            wipe(ne);
            raise_mem[ne] = 1'b1;
          end
          wave_push(n, kind);
        end
      end else if (!raise_mem[ne]) begin
        d = grid_dist(near_mem[e], n, s);
        if (d < dist_mem[ne]) begin
          dist_mem[ne] = 8'(d);
          near_mem[ne] = near_mem[e];
          near_ok[ne]  = 1'b1;
          wave_push(n, kind);
        end
      end
    end
    if (raising) raise_mem[e] = 1'b0;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int s;
    int cidx;
    int kind;
    int e;
    int c;
    int k;
    bit ok;
    s    = side_now();
    cidx = it.cell_req;
    kind = it.kind;
    ok   = cidx < s * s && cidx < CELLS && kind < NUM_KINDS;
    e    = ok ? cidx * NUM_KINDS + kind : 0;
    case (it.opcode)
      OP_CLEAR: wipe_map();
      OP_SET: if (ok) begin
        near_mem[e] = cidx;
        near_ok[e]  = 1'b1;
        dist_mem[e] = 8'd0;
        wave_push(cidx, kind);
      end
      OP_REMOVE: if (ok) begin
        wipe(e);
        raise_mem[e] = 1'b1;
        wave_push(cidx, kind);
      end
      OP_PROP: while (wave_count != 0) begin
        c = wave_cell[wave_head];
        k = wave_kind[wave_head];
        wave_head = (wave_head + 1) % QUEUE_DEPTH;
        wave_count--;
        if (c < CELLS && k < NUM_KINDS && c < s * s) visit_cell(c, k, s);
      end
      default: ;
    endcase
    if (ok && near_ok[e]) begin
      r.distance     = dist_mem[e];
      r.nearest_cell = 12'(near_mem[e]);
      r.has_source   = 1'b1;
    end else begin
      r.distance     = ok ? dist_mem[e] : NO_DIST;
      r.nearest_cell = '0;
      r.has_source   = 1'b0;
    end
    r.queue_overflow = ovf;
    return r;
  endfunction

  initial begin
    side_reg   = SIDE_RESET;
    fail_count = 0;
    exp_wr     = 0;
    exp_rd     = 0;
    wipe_map();
  end

  assign pending = exp_wr - exp_rd;

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_GRID_SIDE)
        side_reg <= pwdata[6:0];
      if (in_valid && in_ready) begin
        exp_mem[exp_wr % EXP_DEPTH] = apply_item(in_data);
        exp_wr++;
      end
      if (out_valid && out_ready) begin
        if (exp_rd == exp_wr) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_data.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, out_data.distance);
            fail_count++;
          end
          if (out_data.nearest_cell !== want.nearest_cell) begin
            $error("nearest_cell: expected %0d, actual %0d",
                   want.nearest_cell, out_data.nearest_cell);
            fail_count++;
          end
          if (out_data.has_source !== want.has_source) begin
            $error("has_source: expected %0d, actual %0d",
                   want.has_source, out_data.has_source);
            fail_count++;
          end
          if (out_data.queue_overflow !== want.queue_overflow) begin
            $error("queue_overflow: expected %0d, actual %0d",
                   want.queue_overflow, out_data.queue_overflow);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/grid_dynamic_distance_map_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dynamic_distance_map_unit_tb: testbench of the grid distance map unit
// Drives directed and random commands under several grid sides, with random
// gaps on the input and stalls on the result side, and leaves all checking
// to the checker instance beside the unit.
// ----------------------------------------------------------------------------
module grid_dynamic_distance_map_unit_tb;
  import gddm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          fail_count;
  bit          gaps_on = 1'b1;
  int          stall_left = 0;

  gddm_chan_if #(.T(in_item_t))  in_if ();
  gddm_chan_if #(.T(out_item_t)) out_if ();

  always #5 clk = ~clk;

  grid_dynamic_distance_map_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gddm_map_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_data    (in_if.data),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_data   (out_if.data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  // The result side stalls in random bursts while gaps are on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Sends one item and returns at the falling edge after it was taken.
  task automatic send_item(op_t op, int cidx, int kind);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_if.data  <= '{opcode: op, cell_req: cidx[11:0], kind: kind[2:0]};
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Waits until every expected result is back and the unit has settled, so
  // that a register write lands while the unit is idle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_side(int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic on the small grid: mostly sets, removes, propagates and
  // queries inside the grid, with a few clears, unknown opcodes and
  // addresses out of range.
  task automatic random_item(int side);
    int pick;
    int cidx;
    int kind;
    op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = OP_SET;
    else if (pick < 40) op = OP_REMOVE;
    else if (pick < 55) op = OP_PROP;
    else if (pick < 92) op = OP_QUERY;
    else if (pick < 95) op = OP_CLEAR;
    else                op = op_t'($urandom_range(5, 7));
    cidx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                       : $urandom_range(0, side * side - 1);
    kind = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
    send_item(op, cidx, kind);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Full 64 by 64 grid after reset: one corner source spreads over the
    // whole layer, and the opposite corner sees the longest distance.
    send_item(OP_QUERY, 0, 0);
    send_item(OP_SET, 0, 0);
    send_item(OP_SET, 4095, 7);
    send_item(OP_QUERY, 4095, 7);
    send_item(OP_PROP, 0, 0);
    send_item(OP_QUERY, 4095, 0);
    send_item(OP_QUERY, 63, 0);
    send_item(op_t'(3'd5), 0, 0);
    send_item(op_t'(3'd7), 4095, 0);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_QUERY, 4095, 0);
    wait_idle();

    // Small grid: two sources, a removal that raises its region, a removal
    // of a cell that never held a source, and a cell beyond the grid.
    write_side(8);
    send_item(OP_SET, 9, 1);
    send_item(OP_SET, 54, 1);
    send_item(OP_PROP, 0, 0);
    send_item(OP_QUERY, 63, 1);
    send_item(OP_REMOVE, 54, 1);
    send_item(OP_REMOVE, 20, 2);
    send_item(OP_SET, 64, 1);
    send_item(OP_PROP, 0, 0);
    send_item(OP_QUERY, 63, 1);
    send_item(OP_QUERY, 20, 2);
    send_item(op_t'(3'd6), 9, 1);
    for (int i = 0; i < 75; i++) begin
      if (i == 55) gaps_on = 1'b0;
      random_item(8);
    end
    wait_idle();

    // A side of zero acts as a one cell grid.
    write_side(0);
    send_item(OP_SET, 0, 3);
    send_item(OP_PROP, 0, 0);
    send_item(OP_QUERY, 0, 3);
    send_item(OP_SET, 1, 3);
    wait_idle();

    // A side above the maximum acts as the full grid; old sources are read
    // back under the new side.
    write_side(127);
    send_item(OP_QUERY, 0, 3);
    send_item(OP_QUERY, 9, 1);
    send_item(OP_SET, 100, 2);
    send_item(OP_QUERY, 100, 2);
    wait_idle();
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("grid_dynamic_distance_map_unit_tb: done, clean");
    end else begin
      $display("grid_dynamic_distance_map_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("grid_dynamic_distance_map_unit_tb: done, errors");
    $finish;
  end

endmodule
